@@ rtl/core/integer_set_table_defines.svh @@
// Assertion macros for the set table.
`ifndef INTEGER_SET_TABLE_DEFINES_SVH
`define INTEGER_SET_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IST_ASSERT(lbl, prop, msg)
`define IST_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/ist_pkg.sv @@
package ist_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic       success;
    logic       full_res;
    logic [4:0] count;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MOVE_WR,
    BK_DONE
  } bk_state_t;

endpackage

@@ rtl/core/ist_front.sv @@
module ist_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ist_pkg::in_item_t in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output ist_pkg::cmd_t    push_cmd
);
  import ist_pkg::*;

  logic fv_r, fv_nxt;
  cmd_t cmd_r, cmd_nxt;

  assign in_ready   = !fv_r || push_ready;
  assign push_valid = fv_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    fv_nxt  = fv_r;
    cmd_nxt = cmd_r;
    if (fv_r && push_ready) begin
      fv_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      fv_nxt        = 1'b1;
      cmd_nxt.op    = op_t'(in_data.opcode);
      cmd_nxt.value = in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

@@ rtl/core/ist_queue.sv @@
module ist_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  ist_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output ist_pkg::cmd_t pop_cmd
);
  import ist_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/ist_back.sv @@
`include "integer_set_table_defines.svh"

module ist_back #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  ist_pkg::cmd_t      cmd_in,
  output logic               out_valid,
  input  logic               out_ready,
  output ist_pkg::out_item_t out_data
);
  import ist_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic [31:0] mem [CAPACITY];
  logic [31:0] rd_data_r;
  logic [IDX_W-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we;

  bk_state_t        state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] last;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             pv_r, pv_nxt;
  logic             ok_r, ok_nxt;
  logic             full_r, full_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        out_r, out_nxt;
  logic             hit;

  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign last      = cnt_r - CNT_W'(1);
  assign hit       = pv_r && (rd_data_r == cmd_r.value);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    slot_nxt  = slot_r;
    pv_nxt    = pv_r;
    ok_nxt    = ok_r;
    full_nxt  = full_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r && !out_ready;
    cmd_pop   = 1'b0;
    raddr     = idx_r[IDX_W-1:0];
    waddr     = cnt_r[IDX_W-1:0];
    wdata     = cmd_r.value;
    we        = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = cmd_in;
          ok_nxt   = 1'b0;
          full_nxt = 1'b0;
          idx_nxt  = '0;
          pv_nxt   = 1'b0;
          if (cmd_in.op == OP_CLEAR) begin
            cnt_nxt   = '0;
            state_nxt = BK_DONE;
          end else begin
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (idx_r != cnt_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end else begin
          pv_nxt = 1'b0;
        end
        if (hit) begin
          slot_nxt = pidx_r;
          case (cmd_r.op)
            OP_REMOVE: begin
              raddr     = last[IDX_W-1:0];
              ok_nxt    = 1'b1;
              state_nxt = BK_MOVE_WR;
            end
            OP_QUERY: begin
              ok_nxt    = 1'b1;
              state_nxt = BK_DONE;
            end
            default: begin
              state_nxt = BK_DONE;
            end
          endcase
        end else if (!pv_r && idx_r == cnt_r) begin
          state_nxt = BK_DONE;
          if (cmd_r.op == OP_ADD) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              full_nxt = 1'b1;
            end else begin
              we      = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
              ok_nxt  = 1'b1;
            end
          end
        end
      end
      BK_MOVE_WR: begin
        we        = 1'b1;
        waddr     = slot_r;
        wdata     = rd_data_r;
        cnt_nxt   = last;
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!ov_r || out_ready) begin
          out_nxt.success  = ok_r;
          out_nxt.full_res = full_r;
          out_nxt.count    = 5'(cnt_r);
          ov_nxt           = 1'b1;
          state_nxt        = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    slot_r <= slot_nxt;
    ok_r   <= ok_nxt;
    full_r <= full_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  `IST_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `IST_ASSERT(a_we_state, we |-> (state_r == BK_SCAN || state_r == BK_MOVE_WR), "stray write")
  `IST_ASSERT(a_ok_full, ov_r |-> !(out_r.success && out_r.full_res), "success with full")
  `IST_ASSERT(a_move_dec, state_r == BK_MOVE_WR |=> cnt_r == $past(last), "remove count slip")

endmodule

@@ rtl/core/integer_set_table.sv @@
// An add that misses goes from input transfer to result through the front register,
// the queue, a scan of the stored entries through the registered memory read port,
// the write-back and the output register. The back end takes one item at a time;
// a clear skips the scan. A two-entry queue lets input transfers continue meanwhile.
// Reset (rst_n, synchronous, active low) empties the set and the queue at once;
// entry storage is not cleared and needs no clearing pass.
module integer_set_table #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ist_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ist_pkg::out_item_t out_data
);
  import ist_pkg::*;

  logic push_valid, push_ready, pop_valid, pop;
  cmd_t push_cmd, pop_cmd;

  ist_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ist_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  ist_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd_in    (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
